// ----- rtl/core/gnta_pkg.sv -----
package gnta_pkg;

   localparam int unsigned TRACK_SLOTS_DEF = 64;
   localparam int unsigned ID_W = 31;
   localparam int unsigned POS_W = 18;
   localparam int unsigned KIND_W = 4;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned RADIUS_W = 16;
   localparam int unsigned DIST_W = 39;
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
   localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd300;
   localparam logic [TIME_W-1:0] EXPIRY_RST = 32'd1000;

   localparam logic CSR_MATCH_RADIUS = 1'b0;
   localparam logic CSR_EXPIRY_TIME = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SPLIT,
      ST_WRITE,
      ST_EXPIRE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] seen;
      logic [ID_W-1:0]   id;
   } slot_type;

endpackage

// ----- rtl/core/gated_nearest_track_association.sv -----
// Channel  | Direction | Ports
// req      | in        | req_valid/req_ready, obstacle fields, frame time, end of frame
// rsp      | out       | rsp_valid/rsp_ready, assigned id, opened/evicted flags
// csr      | in        | csr_valid/csr_ready, csr_index, csr_data
//
// One transaction at a time. An obstacle scans the track memory with one
// read per cycle, through a read stage and two distance stages. The slot
// is then picked in ST_SPLIT and written in ST_WRITE, where the result is
// also registered. End of frame adds an expiry sweep of the memory.
// After reset a clearing pass empties the valid memory before the first
// transaction is accepted. The result sits in an output register, and no
// request is accepted until it has been taken.
module gated_nearest_track_association #(
   parameter int unsigned TRACK_SLOTS = gnta_pkg::TRACK_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_has_obstacle,
   input  logic signed [17:0] req_pos_x,
   input  logic signed [17:0] req_pos_y,
   input  logic [3:0]  req_obstacle_kind,
   input  logic [31:0] req_frame_time,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_assigned_id,
   output logic        rsp_opened_new,
   output logic        rsp_evicted_old,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   localparam int unsigned AW = $clog2(TRACK_SLOTS);
   localparam int unsigned CW = AW + 1;
   localparam logic [CW-1:0] LAST = CW'(TRACK_SLOTS - 1);

   // Track memory and a separate valid-bit memory; both have registered reads.
   gnta_pkg::slot_type mem [TRACK_SLOTS];
   logic vmem [TRACK_SLOTS];

   gnta_pkg::state_type state_ff, state_in;
   logic [CW-1:0] rd_ff, rd_in;         // read address counter
   logic [CW-1:0] idx_d1_ff, idx_d2_ff, idx_d3_ff; // index of data in each stage
   logic v1_ff, v2_ff, v3_ff;           // stage carries a read
   gnta_pkg::slot_type rdat_ff;
   logic rval_ff;
   gnta_pkg::slot_type s2_ff, s3_ff;
   logic ok2_ff, ok3_ff;
   logic [gnta_pkg::DIST_W-1:0] sq_dist;

   logic [15:0] radius_ff;
   logic [31:0] expiry_ff;
   logic [30:0] idc_ff;

   // Latched request.
   logic signed [17:0] x_ff, y_ff;
   logic [3:0] kind_ff;
   logic [31:0] now_ff;
   logic has_ff, eof_ff;

   // Scan results.
   logic best_v_ff; logic [AW-1:0] best_ff; logic [38:0] bestd_ff; logic [30:0] bestid_ff;
   logic same_v_ff; logic [AW-1:0] same_ff;
   logic fre_v_ff;  logic [AW-1:0] fre_ff;
   logic [AW-1:0] old_ff; logic [31:0] oldage_ff;
   logic [30:0] newid_ff;

   logic [AW-1:0] wsel_ff;
   logic [30:0] wid_ff;
   logic op_ff, ev_ff;

   logic [32:0] gate;
   logic [30:0] newid;
   logic        req_acc, scan_done, exp_kill;
   logic [31:0] age3;

   assign gate = 33'(radius_ff) * 33'(radius_ff);
   assign newid = (idc_ff == gnta_pkg::ID_MAX) ? '0 : idc_ff + 31'd1;
   assign req_ready = (state_ff == gnta_pkg::ST_IDLE) && !rsp_valid;
   assign req_acc = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign scan_done = v3_ff && (idx_d3_ff == LAST);
   assign age3 = now_ff - s3_ff.seen;

   gnta_dist u_dist (
      .clock(clock), .ax(x_ff), .ay(y_ff), .bx(rdat_ff.x), .by(rdat_ff.y), .sq_dist(sq_dist)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gnta_pkg::ST_CLEAR:  if (rd_ff == LAST) state_in = gnta_pkg::ST_IDLE;
         gnta_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_has_obstacle) state_in = gnta_pkg::ST_MATCH;
               else if (req_end_of_frame) state_in = gnta_pkg::ST_EXPIRE;
            end
         end
         gnta_pkg::ST_MATCH:  if (scan_done) state_in = gnta_pkg::ST_SPLIT;
         gnta_pkg::ST_SPLIT:  state_in = gnta_pkg::ST_WRITE;
         gnta_pkg::ST_WRITE:
            state_in = eof_ff ? gnta_pkg::ST_EXPIRE : gnta_pkg::ST_IDLE;
         gnta_pkg::ST_EXPIRE: if (scan_done) state_in = gnta_pkg::ST_IDLE;
         default: state_in = gnta_pkg::ST_IDLE;
      endcase
   end

   // Read address issue: one read per cycle during scans and clearing.
   always_comb begin
      rd_in = rd_ff;
      unique case (state_ff)
         gnta_pkg::ST_CLEAR:  rd_in = rd_ff + CW'(1);
         gnta_pkg::ST_MATCH,
         gnta_pkg::ST_EXPIRE: if (rd_ff <= LAST) rd_in = rd_ff + CW'(1);
         default: rd_in = '0;
      endcase
   end

   assign exp_kill = (state_ff == gnta_pkg::ST_EXPIRE) && v3_ff && ok3_ff
                     && (age3 > expiry_ff);

   // Memory ports.
   always_ff @(posedge clock) begin
      rdat_ff <= mem[rd_ff[AW-1:0]];
      rval_ff <= vmem[rd_ff[AW-1:0]];
      if (state_ff == gnta_pkg::ST_WRITE)
         mem[wsel_ff] <= '{x: x_ff, y: y_ff, kind: kind_ff, seen: now_ff, id: wid_ff};
   end

   always_ff @(posedge clock) begin
      if (state_ff == gnta_pkg::ST_CLEAR) vmem[rd_ff[AW-1:0]] <= 1'b0;
      else if (state_ff == gnta_pkg::ST_WRITE) vmem[wsel_ff] <= 1'b1;
      else if (exp_kill) vmem[idx_d3_ff[AW-1:0]] <= 1'b0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gnta_pkg::ST_CLEAR;
         rd_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         radius_ff <= gnta_pkg::RADIUS_RST;
         expiry_ff <= gnta_pkg::EXPIRY_RST;
         idc_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_ff <= rd_in;
         v1_ff <= ((state_ff == gnta_pkg::ST_MATCH) || (state_ff == gnta_pkg::ST_EXPIRE))
                  && (rd_ff <= LAST);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               gnta_pkg::CSR_MATCH_RADIUS: radius_ff <= csr_data[15:0];
               gnta_pkg::CSR_EXPIRY_TIME:  expiry_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == gnta_pkg::ST_SPLIT && !best_v_ff) idc_ff <= newid_ff;
         if (state_ff == gnta_pkg::ST_WRITE) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // Datapath: scan pipeline and per-transaction registers. The slot data
   // and valid bit are delayed to line up with the distance result.
   always_ff @(posedge clock) begin
      idx_d1_ff <= rd_ff;
      idx_d2_ff <= idx_d1_ff;
      idx_d3_ff <= idx_d2_ff;
      s2_ff <= rdat_ff;
      ok2_ff <= rval_ff;
      s3_ff <= s2_ff;
      ok3_ff <= ok2_ff;
      if (req_acc) begin
         x_ff <= req_pos_x; y_ff <= req_pos_y; kind_ff <= req_obstacle_kind;
         now_ff <= req_frame_time; has_ff <= req_has_obstacle;
         eof_ff <= req_end_of_frame;
         best_v_ff <= 1'b0; same_v_ff <= 1'b0; fre_v_ff <= 1'b0;
         old_ff <= '0; oldage_ff <= '0;
         newid_ff <= newid;
      end else if (state_ff == gnta_pkg::ST_MATCH && v3_ff && ok3_ff) begin
         if (s3_ff.kind == kind_ff && sq_dist < gnta_pkg::DIST_W'(gate)) begin
            if (!best_v_ff || sq_dist < bestd_ff ||
                (sq_dist == bestd_ff && s3_ff.id < bestid_ff)) begin
               best_v_ff <= 1'b1; best_ff <= idx_d3_ff[AW-1:0];
               bestd_ff <= sq_dist; bestid_ff <= s3_ff.id;
            end
         end
         if (!same_v_ff && s3_ff.id == newid_ff) begin
            same_v_ff <= 1'b1; same_ff <= idx_d3_ff[AW-1:0];
         end
         if (age3 > oldage_ff) begin
            oldage_ff <= age3; old_ff <= idx_d3_ff[AW-1:0];
         end
      end else if (state_ff == gnta_pkg::ST_MATCH && v3_ff && !ok3_ff && !fre_v_ff) begin
         fre_v_ff <= 1'b1; fre_ff <= idx_d3_ff[AW-1:0];
      end
      if (state_ff == gnta_pkg::ST_SPLIT) begin
         priority if (best_v_ff) begin
            wsel_ff <= best_ff; wid_ff <= bestid_ff; op_ff <= 1'b0; ev_ff <= 1'b0;
         end else if (same_v_ff) begin
            wsel_ff <= same_ff; wid_ff <= newid_ff; op_ff <= 1'b1; ev_ff <= 1'b0;
         end else if (fre_v_ff) begin
            wsel_ff <= fre_ff; wid_ff <= newid_ff; op_ff <= 1'b1; ev_ff <= 1'b0;
         end else begin
            wsel_ff <= old_ff; wid_ff <= newid_ff; op_ff <= 1'b1; ev_ff <= 1'b1;
         end
      end
      if (state_ff == gnta_pkg::ST_WRITE) begin
         rsp_assigned_id <= wid_ff;
         rsp_opened_new <= op_ff;
         rsp_evicted_old <= ev_ff;
      end
   end

   // A result is only produced for requests that carried an obstacle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == gnta_pkg::ST_WRITE |-> has_ff)
      else $error("write without obstacle");
   // Eviction implies a new track was opened.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_old |-> rsp_opened_new)
      else $error("eviction without open");
   // No request is taken while a scan is running.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gnta_pkg::ST_MATCH || state_ff == gnta_pkg::ST_EXPIRE) |-> !req_ready)
      else $error("request taken mid-scan");
endmodule

// ----- rtl/core/gnta_dist.sv -----
// Squared distance of a stored track from the obstacle, registered in two stages.
module gnta_dist (
   input  logic                            clock,
   input  logic signed [gnta_pkg::POS_W-1:0] ax,
   input  logic signed [gnta_pkg::POS_W-1:0] ay,
   input  logic signed [gnta_pkg::POS_W-1:0] bx,
   input  logic signed [gnta_pkg::POS_W-1:0] by,
   output logic [gnta_pkg::DIST_W-1:0]     sq_dist
);
   logic [gnta_pkg::POS_W:0] dx_in, dy_in;
   logic [gnta_pkg::POS_W:0] dx_ff, dy_ff;
   logic signed [gnta_pkg::POS_W:0] sx, sy;
   logic [2*gnta_pkg::POS_W+1:0] qx, qy;

   always_comb begin
      sx = {ax[gnta_pkg::POS_W-1], ax} - {bx[gnta_pkg::POS_W-1], bx};
      sy = {ay[gnta_pkg::POS_W-1], ay} - {by[gnta_pkg::POS_W-1], by};
      dx_in = sx[gnta_pkg::POS_W] ? 19'(-sx) : 19'(sx);
      dy_in = sy[gnta_pkg::POS_W] ? 19'(-sy) : 19'(sy);
      qx = dx_ff * dx_ff;
      qy = dy_ff * dy_ff;
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sq_dist <= gnta_pkg::DIST_W'({1'b0, qx} + {1'b0, qy});
   end
endmodule

// ----- verif/testbench.sv -----
module testbench;

   // One obstacle transaction as offered on the request channel.
   typedef struct packed {
      logic              has;
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic [3:0]        kind;
      logic [31:0]       stamp;
      logic              eof;
   } obstacle_type;

   // One association report as returned on the response channel.
   typedef struct packed {
      logic [30:0] id;
      logic        opened;
      logic        evicted;
   } report_type;

   // Mirror of the track table. Each accepted obstacle is associated here
   // right away, and the report it should produce is queued until the block
   // hands back its own report.
   class track_scoreboard_type;
      bit                 live[gnta_pkg::TRACK_SLOTS_DEF];
      logic [30:0]        ids[gnta_pkg::TRACK_SLOTS_DEF];
      logic signed [17:0] xs[gnta_pkg::TRACK_SLOTS_DEF];
      logic signed [17:0] ys[gnta_pkg::TRACK_SLOTS_DEF];
      logic [3:0]         kinds[gnta_pkg::TRACK_SLOTS_DEF];
      logic [31:0]        seen[gnta_pkg::TRACK_SLOTS_DEF];
      logic [30:0]        id_count;
      logic [15:0]        radius;
      logic [31:0]        expiry;
      report_type         pending[$];
      int                 errors;

      function new();
         for (int i = 0; i < gnta_pkg::TRACK_SLOTS_DEF; i++) begin
            live[i] = 0;
            ids[i] = '0;
            xs[i] = '0;
            ys[i] = '0;
            kinds[i] = '0;
            seen[i] = '0;
         end
         id_count = '0;
         radius = gnta_pkg::RADIUS_RST;
         expiry = gnta_pkg::EXPIRY_RST;
         errors = 0;
      endfunction

      function longint sq_span(logic signed [17:0] a, logic signed [17:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         return d * d;
      endfunction

      function void note_obstacle(obstacle_type it);
         longint      gate;
         longint      span;
         longint      best_span;
         int          best;
         int          same;
         int          free_slot;
         int          oldest;
         logic [31:0] age;
         logic [31:0] oldest_age;
         report_type  rep;
         if (it.has) begin
            gate = longint'(radius) * longint'(radius);
            best = -1;
            best_span = 0;
            for (int i = 0; i < gnta_pkg::TRACK_SLOTS_DEF; i++) begin
               if (live[i] && kinds[i] == it.kind) begin
                  span = sq_span(it.x, xs[i]) + sq_span(it.y, ys[i]);
                  if (span < gate && (best < 0 || span < best_span ||
                      (span == best_span && ids[i] < ids[best]))) begin
                     best = i;
                     best_span = span;
                  end
               end
            end
            rep.opened = 0;
            rep.evicted = 0;
            if (best < 0) begin
               // No gated match: draw the next id, wrapping to zero after
               // the top, and pick a slot for the new track.
               id_count = (id_count == gnta_pkg::ID_MAX) ? '0 : id_count + 31'd1;
               rep.opened = 1;
               same = -1;
               free_slot = -1;
               oldest = 0;
               oldest_age = '0;
               for (int i = 0; i < gnta_pkg::TRACK_SLOTS_DEF; i++) begin
                  if (live[i]) begin
                     age = it.stamp - seen[i];
                     if (same < 0 && ids[i] == id_count)
                        same = i;
                     if (age > oldest_age) begin
                        oldest_age = age;
                        oldest = i;
                     end
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
               if (same >= 0) begin
                  best = same;
               end else if (free_slot >= 0) begin
                  best = free_slot;
               end else begin
                  best = oldest;
                  rep.evicted = 1;
               end
               live[best] = 1;
               ids[best] = id_count;
            end
            rep.id = ids[best];
            xs[best] = it.x;
            ys[best] = it.y;
            kinds[best] = it.kind;
            seen[best] = it.stamp;
            pending.push_back(rep);
         end
         if (it.eof) begin
            for (int i = 0; i < gnta_pkg::TRACK_SLOTS_DEF; i++) begin
               age = it.stamp - seen[i];
               if (live[i] && age > expiry)
                  live[i] = 0;
            end
         end
      endfunction

      function void check_report(logic [30:0] id, logic opened, logic evicted);
         report_type want;
         if (pending.size() == 0) begin
            $error("unexpected report: id %0d opened %0b evicted %0b", id, opened, evicted);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (id !== want.id) begin
            $error("assigned_id: expected %0d, actual %0d", want.id, id);
            errors++;
         end
         if (opened !== want.opened) begin
            $error("opened_new: expected %0b, actual %0b", want.opened, opened);
            errors++;
         end
         if (evicted !== want.evicted) begin
            $error("evicted_old: expected %0b, actual %0b", want.evicted, evicted);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 3000000;
   // An end-of-frame item without obstacle makes no report but still sweeps
   // the table, so settle well past the end of that sweep.
   localparam int SETTLE_CYCLES = 250;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_has_obstacle;
   logic signed [17:0] req_pos_x;
   logic signed [17:0] req_pos_y;
   logic [3:0]  req_obstacle_kind;
   logic [31:0] req_frame_time;
   logic        req_end_of_frame;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [30:0] rsp_assigned_id;
   logic        rsp_opened_new;
   logic        rsp_evicted_old;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   track_scoreboard_type tracks = new();
   bit          steady;      // when set, neither side inserts idle cycles
   int          cycles;
   logic [31:0] now_ms;

   gated_nearest_track_association dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The run is bounded; a hung handshake lands here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Every report taken from the block is checked against the oldest
   // expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracks.check_report(rsp_assigned_id, rsp_opened_new, rsp_evicted_old);
   end

   function int idle_draw();
      return steady ? 0 : $urandom_range(0, 12);
   endfunction

   // The receiver stalls a random number of cycles before each report, unless steady is set.
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         n = idle_draw();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Offer one obstacle transaction, after a random gap, and hold it until
   // the block takes it. Valid is left high so that a following transaction
   // without a gap goes out back to back.
   task automatic send_obstacle(obstacle_type it);
      int n;
      n = idle_draw();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_has_obstacle <= it.has;
      req_pos_x <= it.x;
      req_pos_y <= it.y;
      req_obstacle_kind <= it.kind;
      req_frame_time <= it.stamp;
      req_end_of_frame <= it.eof;
      do @(posedge clock); while (!req_ready);
      tracks.note_obstacle(it);
   endtask

   // Registers are only written with the block idle: all reports back and
   // any trailing expiry sweep finished.
   task automatic write_register(logic idx, logic [31:0] value);
      req_valid <= 1'b0;
      while (tracks.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == gnta_pkg::CSR_MATCH_RADIUS)
         tracks.radius = value[15:0];
      else
         tracks.expiry = value;
   endtask

   function automatic obstacle_type make_item(logic has, int x, int y, int kind,
                                              logic [31:0] stamp, logic eof);
      obstacle_type it;
      it.has = has;
      it.x = 18'(x);
      it.y = 18'(y);
      it.kind = 4'(kind);
      it.stamp = stamp;
      it.eof = eof;
      return it;
   endfunction

   // Random obstacles mostly fall around a grid of 8 x 8 cluster centers so
   // that gating hits, misses and ties all happen. Now and then a field takes
   // a fully random value so every bit toggles, and time occasionally jumps
   // anywhere to exercise wrapping ages.
   function automatic obstacle_type random_item();
      obstacle_type it;
      int cx;
      int cy;
      cx = int'($urandom_range(0, 7)) * 3000 - 12000;
      cy = int'($urandom_range(0, 7)) * 3000 - 12000;
      it.has = ($urandom_range(0, 9) != 0);
      it.x = 18'(cx + int'($urandom_range(0, 800)) - 400);
      it.y = 18'(cy + int'($urandom_range(0, 800)) - 400);
      if ($urandom_range(0, 15) == 0)
         it.x = 18'($urandom());
      if ($urandom_range(0, 15) == 0)
         it.y = 18'($urandom());
      it.kind = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 2));
      it.eof = ($urandom_range(0, 7) == 0);
      it.stamp = now_ms;
      if (it.eof)
         now_ms = ($urandom_range(0, 60) == 0) ? $urandom() : now_ms + $urandom_range(0, 500);
      return it;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0)
            steady = ($urandom_range(0, 3) == 0);
         send_obstacle(random_item());
      end
   endtask

   initial begin
      cycles = 0;
      steady = 0;
      now_ms = 32'd10000;
      reset = 1'b1;
      req_valid = 1'b0;
      req_has_obstacle = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_obstacle_kind = '0;
      req_frame_time = '0;
      req_end_of_frame = 1'b0;
      csr_valid = 1'b0;
      csr_index = gnta_pkg::CSR_MATCH_RADIUS;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings (radius 300, expiry 1000).
      // Tie: two tracks 400 apart, then an obstacle midway; the smaller id
      // must win.
      send_obstacle(make_item(1, 0, 0, 3, 32'd100, 0));
      send_obstacle(make_item(1, 400, 0, 3, 32'd100, 0));
      send_obstacle(make_item(1, 200, 0, 3, 32'd100, 0));
      // Gate edge: exactly on the radius misses, one short of it matches.
      send_obstacle(make_item(1, -5000, 0, 1, 32'd100, 0));
      send_obstacle(make_item(1, -5000, 300, 1, 32'd100, 0));
      send_obstacle(make_item(1, -5000, 599, 1, 32'd100, 0));
      // Same place, other class: never matches.
      send_obstacle(make_item(1, 0, 0, 4, 32'd100, 0));
      // Position and class extremes.
      send_obstacle(make_item(1, 131071, 131071, 15, 32'd100, 0));
      send_obstacle(make_item(1, -131072, -131072, 0, 32'd100, 0));
      send_obstacle(make_item(1, 131071, -131072, 15, 32'd100, 0));
      send_obstacle(make_item(1, 131071, 131071, 15, 32'd100, 0));
      // Expiry edge: age equal to the limit keeps the track, one more drops it.
      send_obstacle(make_item(1, 50000, 50000, 5, 32'd5000, 0));
      send_obstacle(make_item(0, 0, 0, 0, 32'd6000, 1));
      send_obstacle(make_item(1, 50000, 50000, 5, 32'd6000, 0));
      send_obstacle(make_item(0, 0, 0, 0, 32'd7001, 1));
      send_obstacle(make_item(1, 50000, 50000, 5, 32'd7001, 1));
      // Time extremes and a wrap across zero.
      send_obstacle(make_item(1, 70000, 0, 7, 32'hFFFF_FFFF, 0));
      send_obstacle(make_item(1, 70000, 10, 7, 32'h0000_0000, 1));
      send_obstacle(make_item(0, -1, -1, 15, 32'hFFFF_FFFF, 1));
      // No obstacle and no end of frame: nothing happens at all.
      send_obstacle(make_item(0, 12, 34, 2, 32'd100, 0));

      random_phase(300);
      // Zero radius never matches and zero expiry drops everything not seen
      // this very frame.
      write_register(gnta_pkg::CSR_MATCH_RADIUS, 32'd0);
      write_register(gnta_pkg::CSR_EXPIRY_TIME, 32'd0);
      random_phase(250);
      // Widest gate and tracks that never expire.
      write_register(gnta_pkg::CSR_MATCH_RADIUS, 32'h0000_FFFF);
      write_register(gnta_pkg::CSR_EXPIRY_TIME, 32'hFFFF_FFFF);
      random_phase(250);
      // Narrow gate with no expiry: many tracks, steady eviction.
      write_register(gnta_pkg::CSR_MATCH_RADIUS, 32'd150);
      random_phase(300);
      write_register(gnta_pkg::CSR_MATCH_RADIUS, $urandom_range(200, 3000));
      write_register(gnta_pkg::CSR_EXPIRY_TIME, $urandom_range(100, 3000));
      random_phase(300);
      write_register(gnta_pkg::CSR_MATCH_RADIUS, 32'd300);
      write_register(gnta_pkg::CSR_EXPIRY_TIME, 32'd1000);
      random_phase(300);

      req_valid <= 1'b0;
      while (tracks.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracks.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
